>>> sv/first_fit_segment_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top_macros
// Assertion helpers for the segment allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define FFSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffsa_pkg;

  localparam int UNIT_SHIFT = 6;
  localparam logic [15:0] ARENA_RESET = 16'd16384;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    C_NOP,
    C_INIT,
    C_EXACT,
    C_SPLIT,
    C_FREE,
    C_MERGE
  } cop_t;

  // per-cell command decode
  typedef struct packed {
    cop_t op;
    logic is_pos;   // cell is the addressed entry
    logic is_next;  // cell is the entry right after it
    logic shift;    // cell takes its neighbor's entry
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_SCAN_F,
    S_GATHER,
    S_MARK,
    S_UP,
    S_DN,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

>>> sv/ffsa_cell.sv
// ----------------------------------------------------------------------------
// ffsa_cell
// One segment table entry; shifts with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none
module ffsa_cell #(
  parameter bit         FIRST = 1'b0,
  parameter logic [5:0] HDR   = 6'd32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  ffsa_pkg::cell_ctl_t    ctl,
  input  wire  [16:0]            need,
  input  wire  [21:0]            size,
  input  wire  [21:0]            off,
  input  wire  [15:0]            cfg_units,
  input  wire  [15:0]            lo_st,
  input  wire  [15:0]            lo_un,
  input  wire                    lo_used,
  input  wire  [21:0]            lo_rb,
  input  wire  [15:0]            hi_st,
  input  wire  [15:0]            hi_un,
  input  wire                    hi_used,
  input  wire  [21:0]            hi_rb,
  output logic [15:0]            st_r,
  output logic [15:0]            un_r,
  output logic                   used_r,
  output logic [21:0]            rb_r,
  output logic                   fit,
  output logic                   eq,
  output logic                   match
);
  import ffsa_pkg::*;

  logic [15:0] st_nxt, un_nxt;
  logic        used_nxt;
  logic [21:0] rb_nxt;
  logic [21:0] pay;

  assign pay   = {st_r, 6'd0} + {16'd0, HDR};
  assign fit   = !used_r && ({1'b0, un_r} >= need);
  assign eq    = ({1'b0, un_r} == need);
  assign match = used_r && (pay == off);

  always_comb begin
    st_nxt   = st_r;
    un_nxt   = un_r;
    used_nxt = used_r;
    rb_nxt   = rb_r;
    case (ctl.op)
      C_INIT: begin
        used_nxt = 1'b0;
        if (ctl.is_pos) begin
          st_nxt = 16'd0;
          un_nxt = cfg_units;
        end
      end
      C_EXACT: begin
        if (ctl.is_pos) begin
          used_nxt = 1'b1;
          rb_nxt   = size;
        end
      end
      C_SPLIT: begin
        if (ctl.is_pos) begin
          un_nxt = un_r - need[15:0];
        end else if (ctl.is_next) begin
          st_nxt   = lo_st + lo_un - need[15:0];
          un_nxt   = need[15:0];
          used_nxt = 1'b1;
          rb_nxt   = size;
        end else if (ctl.shift) begin
          st_nxt   = lo_st;
          un_nxt   = lo_un;
          used_nxt = lo_used;
          rb_nxt   = lo_rb;
        end
      end
      C_FREE: begin
        if (ctl.is_pos) used_nxt = 1'b0;
      end
      C_MERGE: begin
        if (ctl.is_pos) begin
          un_nxt = un_r + hi_un;
        end else if (ctl.shift) begin
          st_nxt   = hi_st;
          un_nxt   = hi_un;
          used_nxt = hi_used;
          rb_nxt   = hi_rb;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= 16'd0;
      un_r   <= FIRST ? ARENA_RESET : 16'd0;
      used_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      un_r   <= un_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rb_r <= rb_nxt;
  end

endmodule
`default_nettype wire

>>> sv/first_fit_segment_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top
// First-fit arena allocator with coalescing over a chain of segment cells.
// ----------------------------------------------------------------------------
// One beat in gives one status beat out. Allocate takes need =
// ((size + HEADER_BYTES) >> 6) + 1 units and walks the table one entry per
// cycle from the top entry down. Free walks upward from entry 0 for the
// matching used entry, then steps through S_MARK, S_UP and S_DN for the
// release and the two merges. The block returns to S_IDLE before the next
// beat is taken. The walk is the rate limiter; each cell compares itself to
// the request in parallel and insert/delete is a neighbor shift along the
// chain. A new beat is taken while the previous result still sits in the
// output register. Writing arena_units in S_IDLE resets the table to one
// free segment and clears both counters; a write outside S_IDLE has no
// effect. The input is held off in the cycle of the write.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_segment_allocator_top_macros.svh"
module first_fit_segment_allocator_top #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_arena_units,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_req_type,
  input  wire  [21:0] in_req_size,
  input  wire  [21:0] in_free_offset,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_status,
  output logic [21:0] out_payload_offset,
  output logic [21:0] out_bytes_in_use,
  output logic [6:0]  out_live_allocations
);
  import ffsa_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [5:0] HDR = 6'(HEADER_BYTES);

  state_t state_r, state_nxt;

  // request latch
  logic        type_r;
  logic [21:0] size_r, off_r;
  logic [16:0] need_r;
  logic [22:0] need_sum;

  // bookkeeping
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [21:0]   bytes_r, bytes_nxt;
  logic [CW-1:0] alloc_r, alloc_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [21:0]   poff_r, poff_nxt;

  // output register
  logic          out_valid_r;
  logic [1:0]    o_status_r;
  logic [21:0]   o_off_r, o_bytes_r;
  logic [6:0]    o_live_r;
  logic          load_out;

  // command to the chain
  cop_t          cop;
  logic [IW-1:0] cpos;

  // cell arrays
  logic [15:0] st_w [MAX_SEGMENTS];
  logic [15:0] un_w [MAX_SEGMENTS];
  logic        used_w [MAX_SEGMENTS];
  logic [21:0] rb_w [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] fit_v, eq_v, match_v, used_v;
  logic [15:0] sel_st;
  logic [21:0] sel_rb;

  logic [IW-1:0] scan_ix;
  logic [IW:0]   pos_p1;

  assign scan_ix  = scan_r[IW-1:0];
  assign pos_p1   = {1'b0, pos_r} + 1'b1;
  assign need_sum = {1'b0, in_req_size} + {17'd0, HDR};

  // a configuration write takes the idle cycle, so no beat is taken with it
  assign in_stall = (state_r != S_IDLE) || cfg_we;

  // ---- the chain of cells ----
  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    localparam int KL = (k == 0) ? 0 : k - 1;
    localparam int KH = (k == MAX_SEGMENTS - 1) ? k : k + 1;
    localparam logic [IW:0] KI = (IW + 1)'(k);
    cell_ctl_t ctl;
    logic [IW:0] cp;
    assign cp          = {1'b0, cpos};
    assign ctl.op      = cop;
    assign ctl.is_pos  = (KI == cp);
    assign ctl.is_next = (KI == cp + 1'b1);
    assign ctl.shift   = (cop == C_SPLIT) ? (KI > cp + 1'b1) : (KI > cp);

    ffsa_cell #(.FIRST(k == 0), .HDR(HDR)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .need(need_r), .size(size_r), .off(off_r), .cfg_units(cfg_arena_units),
      .lo_st(st_w[KL]), .lo_un(un_w[KL]), .lo_used(used_w[KL]), .lo_rb(rb_w[KL]),
      .hi_st(st_w[KH]), .hi_un(un_w[KH]), .hi_used(used_w[KH]), .hi_rb(rb_w[KH]),
      .st_r(st_w[k]), .un_r(un_w[k]), .used_r(used_w[k]), .rb_r(rb_w[k]),
      .fit(fit_v[k]), .eq(eq_v[k]), .match(match_v[k])
    );
    assign used_v[k] = used_w[k];
  end

  // pick out the entry at pos_r
  always_comb begin
    sel_st = 16'd0;
    sel_rb = 22'd0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      if (pos_r == IW'(k)) begin
        sel_st = sel_st | st_w[k];
        sel_rb = sel_rb | rb_w[k];
      end
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    scan_nxt  = scan_r;
    pos_nxt   = pos_r;
    bytes_nxt = bytes_r;
    alloc_nxt = alloc_r;
    stat_nxt  = stat_r;
    poff_nxt  = poff_r;
    cop       = C_NOP;
    cpos      = pos_r;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          cop       = C_INIT;
          cpos      = '0;
          count_nxt = CW'(1);
          bytes_nxt = 22'd0;
          alloc_nxt = '0;
        end else if (in_valid) begin
          poff_nxt = 22'd0;
          if (!in_req_type) begin
            scan_nxt  = count_r - 1'b1;
            state_nxt = S_SCAN_A;
          end else begin
            scan_nxt  = '0;
            state_nxt = S_SCAN_F;
          end
        end
      end
      S_SCAN_A: begin
        cpos = scan_ix;
        if (fit_v[scan_ix]) begin
          if (eq_v[scan_ix]) begin
            cop       = C_EXACT;
            pos_nxt   = scan_ix;
            state_nxt = S_GATHER;
          end else if (count_r >= CW'(MAX_SEGMENTS)) begin
            stat_nxt  = ST_FULL;
            state_nxt = S_RESP;
          end else begin
            cop       = C_SPLIT;
            pos_nxt   = scan_ix + 1'b1;
            count_nxt = count_r + 1'b1;
            state_nxt = S_GATHER;
          end
        end else if (scan_r == '0) begin
          stat_nxt  = ST_NO_FIT;
          state_nxt = S_RESP;
        end else begin
          scan_nxt = scan_r - 1'b1;
        end
      end
      S_GATHER: begin
        poff_nxt  = {sel_st, 6'd0} + {16'd0, HDR};
        bytes_nxt = bytes_r + size_r;
        alloc_nxt = alloc_r + 1'b1;
        stat_nxt  = ST_OK;
        state_nxt = S_RESP;
      end
      S_SCAN_F: begin
        if (scan_r >= count_r) begin
          stat_nxt  = ST_UNKNOWN;
          state_nxt = S_RESP;
        end else if (match_v[scan_ix]) begin
          pos_nxt   = scan_ix;
          state_nxt = S_MARK;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_MARK: begin
        cop       = C_FREE;
        bytes_nxt = bytes_r - sel_rb;
        if (alloc_r != '0) alloc_nxt = alloc_r - 1'b1;
        state_nxt = S_UP;
      end
      S_UP: begin
        // merge with the free entry above
        if ((CW + 1)'(pos_p1) < (CW + 1)'(count_r) && !used_v[pos_p1[IW-1:0]]) begin
          cop       = C_MERGE;
          count_nxt = count_r - 1'b1;
        end
        state_nxt = S_DN;
      end
      S_DN: begin
        // merge into the free entry below
        cpos = pos_r - 1'b1;
        if (pos_r != '0 && !used_v[cpos]) begin
          cop       = C_MERGE;
          count_nxt = count_r - 1'b1;
        end
        stat_nxt  = ST_OK;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CW'(1);
      bytes_r     <= 22'd0;
      alloc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      bytes_r <= bytes_nxt;
      alloc_r <= alloc_nxt;
      if (load_out)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    pos_r  <= pos_nxt;
    stat_r <= stat_nxt;
    poff_r <= poff_nxt;
    if (state_r == S_IDLE && in_valid && !cfg_we) begin
      type_r <= in_req_type;
      size_r <= in_req_size;
      off_r  <= in_free_offset;
      need_r <= 17'(need_sum >> UNIT_SHIFT) + 17'd1;
    end
    if (load_out) begin
      o_status_r <= stat_r;
      o_off_r    <= (stat_r == ST_OK && !type_r) ? poff_r : 22'd0;
      o_bytes_r  <= bytes_r;
      o_live_r   <= 7'(alloc_r);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = o_status_r;
  assign out_payload_offset   = o_off_r;
  assign out_bytes_in_use     = o_bytes_r;
  assign out_live_allocations = o_live_r;

  // ---- checks ----
  `FFSA_ASSERT_NOW(a_count_range, 1'b1, count_r >= CW'(1) && count_r <= CW'(MAX_SEGMENTS), "segment count out of range")
  `FFSA_ASSERT_NOW(a_scan_in_table, state_r == S_SCAN_A, scan_r < count_r, "allocate walk left the table")
  `FFSA_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid_r && state_r == S_IDLE, "result beat not presented")

endmodule
`default_nettype wire

>>> verif/ffsa_checker.sv
// ----------------------------------------------------------------------------
// ffsa_checker
// Watches the allocator's channels, keeps a shadow segment table and
// compares every result beat against the predicted status, offset and counters.
// ----------------------------------------------------------------------------
module ffsa_checker #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire [15:0] cfg_arena_units,
  input  wire        in_valid,
  input  wire        in_stall,
  input  wire        in_req_type,
  input  wire [21:0] in_req_size,
  input  wire [21:0] in_free_offset,
  input  wire        out_valid,
  input  wire        out_stall,
  input  wire [1:0]  out_status,
  input  wire [21:0] out_payload_offset,
  input  wire [21:0] out_bytes_in_use,
  input  wire [6:0]  out_live_allocations,
  output int         fail_count,
  output int         pending
);
  import ffsa_pkg::*;

  typedef struct {
    status_t     status;
    logic [21:0] offset;
    logic [21:0] bytes;
    logic [6:0]  live;
  } reply_t;

  reply_t      replies_due[$];

  logic [15:0] sh_start [MAX_SEGMENTS];
  logic [15:0] sh_units [MAX_SEGMENTS];
  bit          sh_used  [MAX_SEGMENTS];
  logic [21:0] sh_bytes [MAX_SEGMENTS];
  int          sh_count;
  logic [21:0] sh_total;
  logic [6:0]  sh_live;

  assign pending = replies_due.size();

  function automatic void wipe_table(logic [15:0] arena);
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      sh_start[i] = '0;
      sh_units[i] = '0;
      sh_used[i]  = 0;
      sh_bytes[i] = '0;
    end
    sh_units[0] = arena;
    sh_count    = 1;
    sh_total    = '0;
    sh_live     = '0;
  endfunction

  function automatic void remove_seg(int k);
    for (int j = k; j + 1 < sh_count; j++) begin
      sh_start[j] = sh_start[j+1];
      sh_units[j] = sh_units[j+1];
      sh_used[j]  = sh_used[j+1];
      sh_bytes[j] = sh_bytes[j+1];
    end
    sh_count--;
  endfunction

  function automatic reply_t grant_or_release(bit is_free, logic [21:0] size,
                                              logic [21:0] foff);
    reply_t r;
    int     need;
    int     k;
    logic [21:0] pay;
    r.status = ST_NO_FIT;
    r.offset = '0;
    if (!is_free) begin
      need = ((int'(size) + HEADER_BYTES) >> UNIT_SHIFT) + 1;
      for (k = sh_count - 1; k >= 0; k--) begin
        if (sh_used[k] || int'(sh_units[k]) < need) continue;
        if (int'(sh_units[k]) != need) begin
          if (sh_count >= MAX_SEGMENTS) begin
            r.status = ST_FULL;
            break;
          end
          for (int j = sh_count; j > k + 1; j--) begin
            sh_start[j] = sh_start[j-1];
            sh_units[j] = sh_units[j-1];
            sh_used[j]  = sh_used[j-1];
            sh_bytes[j] = sh_bytes[j-1];
          end
          sh_units[k]   = sh_units[k] - 16'(need);
          sh_start[k+1] = sh_start[k] + sh_units[k];
          sh_units[k+1] = 16'(need);
          sh_count++;
          k++;
        end
        sh_used[k]  = 1;
        sh_bytes[k] = size;
        r.status    = ST_OK;
        r.offset    = 22'((int'(sh_start[k]) << UNIT_SHIFT) + HEADER_BYTES);
        sh_total    = sh_total + size;
        sh_live     = sh_live + 7'd1;
        break;
      end
    end else begin
      r.status = ST_UNKNOWN;
      for (k = 0; k < sh_count; k++) begin
        pay = 22'((int'(sh_start[k]) << UNIT_SHIFT) + HEADER_BYTES);
        if (sh_used[k] && pay == foff) break;
      end
      if (k < sh_count) begin
        r.status   = ST_OK;
        sh_used[k] = 0;
        sh_total   = sh_total - sh_bytes[k];
        if (sh_live > 0) sh_live = sh_live - 7'd1;
        if (k + 1 < sh_count && !sh_used[k+1]) begin
          sh_units[k] = sh_units[k] + sh_units[k+1];
          remove_seg(k + 1);
        end
        if (k > 0 && !sh_used[k-1]) begin
          sh_units[k-1] = sh_units[k-1] + sh_units[k];
          remove_seg(k);
        end
      end
    end
    r.bytes = sh_total;
    r.live  = sh_live;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    wipe_table(ARENA_RESET);
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      replies_due.delete();
      wipe_table(ARENA_RESET);
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected beat, status", 32'(out_status), 32'd0);
        end else begin
          want = replies_due.pop_front();
          if (out_status != want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_payload_offset != want.offset)
            report_mismatch("payload_offset", 32'(out_payload_offset),
                            32'(want.offset));
          if (out_bytes_in_use != want.bytes)
            report_mismatch("bytes_in_use", 32'(out_bytes_in_use), 32'(want.bytes));
          if (out_live_allocations != want.live)
            report_mismatch("live_allocations", 32'(out_live_allocations),
                            32'(want.live));
        end
      end
      if (cfg_we) wipe_table(cfg_arena_units);
      if (in_valid && !in_stall)
        replies_due.push_back(grant_or_release(in_req_type, in_req_size,
                                               in_free_offset));
    end
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the first-fit segment allocator: directed corner
// beats, then random allocate/free traffic over several arena sizes and
// handshake idling patterns; a checker module does all the comparing.
// ----------------------------------------------------------------------------
module tb;
  import ffsa_pkg::*;

  localparam int MAX_SEG = 64;
  localparam int HDR     = 32;

  logic        clk = 0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_arena_units;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [21:0] in_req_size;
  logic [21:0] in_free_offset;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [21:0] out_payload_offset;
  logic [21:0] out_bytes_in_use;
  logic [6:0]  out_live_allocations;
  int          fail_count;
  int          pending;

  // handshake idling, in percent
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          squeeze;      // long receiver hold-off requested
  int          squeeze_cnt = 0;

  // payload offsets granted and not yet freed, harvested from result beats
  logic [21:0] live_offsets[$];

  always #5 clk = ~clk;

  first_fit_segment_allocator_top #(
    .MAX_SEGMENTS(MAX_SEG),
    .HEADER_BYTES(HDR)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_arena_units(cfg_arena_units),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_req_size(in_req_size),
    .in_free_offset(in_free_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_payload_offset(out_payload_offset),
    .out_bytes_in_use(out_bytes_in_use),
    .out_live_allocations(out_live_allocations)
  );

  ffsa_checker #(
    .MAX_SEGMENTS(MAX_SEG),
    .HEADER_BYTES(HDR)
  ) chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_arena_units(cfg_arena_units),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_req_size(in_req_size),
    .in_free_offset(in_free_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_payload_offset(out_payload_offset),
    .out_bytes_in_use(out_bytes_in_use),
    .out_live_allocations(out_live_allocations),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: random stall, or a long solid hold-off while squeeze is set.
  // The hold-off is counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (squeeze && squeeze_cnt < 600) begin
      out_stall   <= 1'b1;
      squeeze_cnt <= squeeze_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!squeeze) squeeze_cnt <= 0;
    end
  end

  // Harvest granted offsets so frees mostly hit live allocations.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_status == ST_OK &&
        out_payload_offset != '0)
      live_offsets.push_back(out_payload_offset);
  end

  // One request beat; idle gaps go before it, valid stays up after it.
  task automatic send_beat(bit is_free, logic [21:0] size, logic [21:0] foff);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= is_free;
    in_req_size    <= size;
    in_free_offset <= foff;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // longest walk of the block plus margin
    repeat (MAX_SEG + 16) @(posedge clk);
  endtask

  // Only between phases, with the block drained.
  task automatic set_arena(logic [15:0] units);
    drain();
    cfg_we          <= 1'b1;
    cfg_arena_units <= units;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_offsets.delete();
  endtask

  task automatic release_live(int pick);
    logic [21:0] off;
    off = live_offsets[pick];
    live_offsets.delete(pick);
    send_beat(1'b1, 22'($urandom), off);
  endtask

  // Random traffic: mostly small allocations and frees of live offsets,
  // with oversized requests and stray frees mixed in as noise.
  task automatic random_traffic(int beats, int alloc_pct);
    int roll;
    for (int n = 0; n < beats; n++) begin
      roll = $urandom_range(99);
      if (roll < alloc_pct || (roll < 92 && live_offsets.size() == 0)) begin
        roll = $urandom_range(99);
        if (roll < 75)
          send_beat(1'b0, 22'($urandom_range(0, 2000)), 22'($urandom));
        else if (roll < 93)
          send_beat(1'b0, 22'($urandom_range(0, 300000)), 22'($urandom));
        else
          send_beat(1'b0, 22'($urandom), 22'($urandom));
      end else if (roll < 92) begin
        release_live($urandom_range(0, live_offsets.size() - 1));
      end else begin
        send_beat(1'b1, 22'($urandom), 22'($urandom));  // almost always unknown offset
      end
    end
  endtask

  task automatic traffic_phase(logic [15:0] arena, int idle, int stall, int beats,
                               int alloc_pct);
    set_arena(arena);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    random_traffic(beats, alloc_pct);
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_arena_units <= '0;
    in_valid        <= 1'b0;
    in_req_type     <= 1'b0;
    in_req_size     <= '0;
    in_free_offset  <= '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    squeeze         = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, on the reset arena: field extremes, split, no-fit.
    send_beat(1'b0, 22'd0, 22'h3FFFFF);
    send_beat(1'b0, 22'h3FFFFF, 22'd0);      // need far above arena
    send_beat(1'b0, 22'd31, 22'd0);          // still one unit
    send_beat(1'b0, 22'd32, 22'd0);          // two units
    send_beat(1'b0, 22'd4000, 22'd0);
    drain();
    // free in the middle, then neighbors on both sides -> coalescing
    release_live(2);
    release_live(0);
    release_live(0);
    send_beat(1'b1, 22'd0, 22'd0);           // offset of nothing
    send_beat(1'b1, 22'd0, 22'h3FFFFF);
    drain();
    send_beat(1'b1, 22'd0, live_offsets[0]); // live one
    send_beat(1'b1, 22'd0, live_offsets[0]); // now a double free

    // Exact fit on a three-unit arena.
    set_arena(16'd3);
    repeat (4) send_beat(1'b0, 22'd0, 22'd0);
    // Zero arena: nothing fits.
    set_arena(16'd0);
    send_beat(1'b0, 22'd0, 22'd0);
    send_beat(1'b1, 22'd0, 22'd32);
    // One-unit arena, then fill the table on the largest arena.
    set_arena(16'd1);
    send_beat(1'b0, 22'd0, 22'd0);
    send_beat(1'b0, 22'd0, 22'd0);
    set_arena(16'hFFFF);
    repeat (66) send_beat(1'b0, 22'($urandom_range(0, 40)), 22'd0);

    // Random phases over arena sizes and idling patterns.
    traffic_phase(16'd16384, 0, 0, 220, 55);
    traffic_phase(16'hFFFF, 82, 0, 200, 60);
    traffic_phase(16'd300, 0, 82, 200, 55);
    traffic_phase(16'd64, 23, 23, 180, 60);
    traffic_phase(16'($urandom_range(1, 65535)), 0, 0, 200, 70);

    // Pressure: receiver holds off while the sender keeps offering.
    set_arena(16'd5000);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    squeeze        = 1;
    random_traffic(40, 60);
    squeeze        = 0;

    traffic_phase(16'd2, 23, 23, 120, 55);
    traffic_phase(16'd16384, 0, 0, 400, 50);

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #80_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> first_fit_segment_allocator_top.f
+incdir+sv
sv/ffsa_pkg.sv
sv/ffsa_cell.sv
sv/first_fit_segment_allocator_top.sv
verif/ffsa_checker.sv
verif/tb.sv
